FILE: hdl/fnv_pkg.sv
// ----------------------------------------------------------------------------
// fnv_pkg
// types, constants and the byte step shared by the typed signature blocks
// ----------------------------------------------------------------------------
package fnv_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_BOOL   = 3'd0,
        OP_U32    = 3'd1,
        OP_U64    = 3'd2,
        OP_F32    = 3'd3,
        OP_FINISH = 3'd4
    } t_opcode;

    typedef struct packed {
        logic        finish;
        logic [3:0]  nbytes;
        logic [63:0] data;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_FOLD
    } t_back_state;

    // xor one byte, then multiply by the prime 2^40 + 435 as shifts and adds
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

FILE: hdl/fnv1a64_typed_signature.sv
// a finish passes the front register and the queue, then the signature is registered
// the hash engine folds one byte per cycle while commands are queued: 1 byte for bool,
//   4 for u32 and float32, 8 for u64; one xor-multiply step per cycle sets this rate
// the command queue lets the front take items while the engine is busy
// reset: synchronous active low; hash restarts at the offset basis, queues empty
// ----------------------------------------------------------------------------
// fnv1a64_typed_signature
// 64-bit fnv-1a signature over typed values, queue style ports on both sides
// ----------------------------------------------------------------------------
module fnv1a64_typed_signature #(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_opcode,
    input  logic [63:0] i_operand_value,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_signature
);

    logic          w_fwd_valid;
    fnv_pkg::t_cmd w_fwd_cmd;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_q_rd;
    fnv_pkg::t_cmd w_q_cmd;

    fnv_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_operand_value (i_operand_value),
        .o_cmd_valid     (w_fwd_valid),
        .o_cmd           (w_fwd_cmd),
        .i_cmd_full      (w_q_full)
    );

    fnv_cmd_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_fwd_valid),
        .i_wr_cmd (w_fwd_cmd),
        .o_full   (w_q_full),
        .i_rd     (w_q_rd),
        .o_rd_cmd (w_q_cmd),
        .o_empty  (w_q_empty)
    );

    fnv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_q_empty),
        .i_cmd       (w_q_cmd),
        .o_cmd_rd    (w_q_rd),
        .empty       (empty),
        .pop         (pop),
        .o_signature (o_signature)
    );

`ifndef SYNTHESIS
    a_sig_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_signature != 64'd0))
        else $error("signature of zero shown");

    a_full_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (w_fwd_valid && w_q_full))
        else $error("full raised without a held item");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fwd_valid && w_q_full) |=> (w_fwd_valid && $stable(w_fwd_cmd)))
        else $error("held item lost while queue full");

    a_rd_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_rd |-> !w_q_empty)
        else $error("engine read from empty queue");
`endif

endmodule

FILE: hdl/fnv_front.sv
// ----------------------------------------------------------------------------
// fnv_front
// accepts items, decodes the opcode into a byte-fold or finish command, drops unknown opcodes
// ----------------------------------------------------------------------------
module fnv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          i_opcode,
    input  logic [63:0]         i_operand_value,
    output logic                o_cmd_valid,
    output fnv_pkg::t_cmd       o_cmd,
    input  logic                i_cmd_full
);

    logic          r_valid;
    logic          n_valid;
    fnv_pkg::t_cmd r_cmd;
    fnv_pkg::t_cmd n_cmd;
    logic          w_known;
    fnv_pkg::t_cmd w_dec;
    logic          w_accept;

    always_comb begin
        w_known = 1'b1;
        w_dec   = '0;
        case (i_opcode)
            fnv_pkg::OP_BOOL: begin
                w_dec.nbytes = 4'd1;
                w_dec.data   = {63'd0, |i_operand_value};
            end
            fnv_pkg::OP_U32: begin
                w_dec.nbytes = 4'd4;
                w_dec.data   = {32'd0, i_operand_value[31:0]};
            end
            fnv_pkg::OP_U64: begin
                w_dec.nbytes = 4'd8;
                w_dec.data   = i_operand_value;
            end
            fnv_pkg::OP_F32: begin
                w_dec.nbytes = 4'd4;
                if (i_operand_value[31:0] == fnv_pkg::F32_NEG_ZERO) begin
                    w_dec.data = 64'd0;
                end else begin
                    w_dec.data = {32'd0, i_operand_value[31:0]};
                end
            end
            fnv_pkg::OP_FINISH: begin
                w_dec.finish = 1'b1;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign full     = r_valid && i_cmd_full;
    assign w_accept = push && !full;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (r_valid && !i_cmd_full) begin
            n_valid = 1'b0;
        end
        if (w_accept && w_known) begin
            n_valid = 1'b1;
            n_cmd   = w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

FILE: hdl/fnv_cmd_fifo.sv
// ----------------------------------------------------------------------------
// fnv_cmd_fifo
// short command queue between the decode front and the hash engine
// ----------------------------------------------------------------------------
module fnv_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  fnv_pkg::t_cmd i_wr_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output fnv_pkg::t_cmd o_rd_cmd,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    fnv_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full   = (r_cnt == FULL_CNT);
    assign o_empty  = (r_cnt == '0);
    assign w_wr     = i_wr && !o_full;
    assign w_rd     = i_rd && !o_empty;
    assign o_rd_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_wr) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

endmodule

FILE: hdl/fnv_back.sv
// ----------------------------------------------------------------------------
// fnv_back
// hash engine: folds one byte per cycle while commands are queued, emits the signature on finish
// ----------------------------------------------------------------------------
module fnv_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_empty,
    input  fnv_pkg::t_cmd i_cmd,
    output logic          o_cmd_rd,
    output logic          empty,
    input  logic          pop,
    output logic [63:0]   o_signature
);

    fnv_pkg::t_back_state r_state;
    fnv_pkg::t_back_state n_state;
    logic [63:0] r_hash;
    logic [63:0] n_hash;
    logic [63:0] r_shift;
    logic [63:0] n_shift;
    logic [3:0]  r_left;
    logic [3:0]  n_left;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [63:0] r_out_sig;
    logic [63:0] n_out_sig;
    logic        w_slot_free;

    assign w_slot_free = !r_out_valid || pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fnv_pkg::BK_IDLE: begin
                if (!i_cmd_empty && !i_cmd.finish && (i_cmd.nbytes != 4'd1)) begin
                    n_state = fnv_pkg::BK_FOLD;
                end
            end
            fnv_pkg::BK_FOLD: begin
                if (r_left == 4'd1) begin
                    n_state = fnv_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = fnv_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_rd    = 1'b0;
        n_hash      = r_hash;
        n_shift     = r_shift;
        n_left      = r_left;
        n_out_valid = r_out_valid && !pop;
        n_out_sig   = r_out_sig;
        case (r_state)
            fnv_pkg::BK_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.finish) begin
                        if (w_slot_free) begin
                            o_cmd_rd    = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_sig   = (r_hash == 64'd0) ? 64'd1 : r_hash;
                            n_hash      = fnv_pkg::FNV_BASIS;
                        end
                    end else begin
                        o_cmd_rd = 1'b1;
                        n_hash   = fnv_pkg::fnv_step(r_hash, i_cmd.data[7:0]);
                        n_shift  = i_cmd.data >> 8;
                        n_left   = i_cmd.nbytes - 4'd1;
                    end
                end
            end
            fnv_pkg::BK_FOLD: begin
                n_hash  = fnv_pkg::fnv_step(r_hash, r_shift[7:0]);
                n_shift = r_shift >> 8;
                n_left  = r_left - 4'd1;
            end
            default: begin
                n_left = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fnv_pkg::BK_IDLE;
            r_hash      <= fnv_pkg::FNV_BASIS;
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
        end
        r_shift   <= n_shift;
        r_out_sig <= n_out_sig;
    end

    assign empty       = !r_out_valid;
    assign o_signature = r_out_sig;

endmodule

FILE: tb/fnv1a64_typed_signature_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fnv1a64_typed_signature_test
// self-checking bench for the 64-bit fnv-1a typed signature block: a directed
// table of corner items, then random typed items with random push and pop
// gaps, each signature compared against its table value or a bit-exact predictor
// ----------------------------------------------------------------------------
module fnv1a64_typed_signature_test;

    localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
    localparam logic [2:0]  OP_SPARE_5 = 3'd5;
    localparam logic [2:0]  OP_SPARE_6 = 3'd6;
    localparam logic [2:0]  OP_SPARE_7 = 3'd7;
    localparam int          RANDOM_ITEMS = 870;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          GAP_MAX = 19;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] val;
        logic        known;
        logic [63:0] sig;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_opcode = fnv_pkg::OP_BOOL;
    logic [63:0] i_operand_value = 64'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [63:0] o_signature;

    logic [63:0] running_hash = fnv_pkg::FNV_BASIS;
    logic [63:0] pending_signatures [$];
    int          failures = 0;
    int          cycle_count = 0;
    bit          sender_quiet = 1'b0;
    bit          receiver_quiet = 1'b0;

    t_row directed_rows [0:22] = '{
        '{fnv_pkg::OP_FINISH, 64'd0,                   1'b1, fnv_pkg::FNV_BASIS},
        '{fnv_pkg::OP_FINISH, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, fnv_pkg::FNV_BASIS},
        '{OP_SPARE_5,         64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
        '{OP_SPARE_6,         64'h0123_4567_89AB_CDEF, 1'b0, 64'd0},
        '{OP_SPARE_7,         64'h8000_0000_0000_0001, 1'b0, 64'd0},
        '{fnv_pkg::OP_FINISH, 64'd0,                   1'b1, fnv_pkg::FNV_BASIS},
        '{fnv_pkg::OP_BOOL,   64'd0,                   1'b0, 64'd0},
        '{fnv_pkg::OP_BOOL,   64'd1,                   1'b0, 64'd0},
        '{fnv_pkg::OP_BOOL,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
        '{fnv_pkg::OP_BOOL,   64'h8000_0000_0000_0000, 1'b0, 64'd0},
        '{fnv_pkg::OP_FINISH, 64'd0,                   1'b0, 64'd0},
        '{fnv_pkg::OP_U32,    64'd0,                   1'b0, 64'd0},
        '{fnv_pkg::OP_U32,    64'h0000_0000_FFFF_FFFF, 1'b0, 64'd0},
        '{fnv_pkg::OP_U32,    64'hFFFF_FFFF_0000_0000, 1'b0, 64'd0},
        '{fnv_pkg::OP_U64,    64'd0,                   1'b0, 64'd0},
        '{fnv_pkg::OP_U64,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
        '{fnv_pkg::OP_FINISH, 64'd0,                   1'b0, 64'd0},
        '{fnv_pkg::OP_F32,    {32'd0, fnv_pkg::F32_NEG_ZERO}, 1'b0, 64'd0},
        '{fnv_pkg::OP_F32,    64'd0,                   1'b0, 64'd0},
        '{fnv_pkg::OP_F32,    {32'hDEAD_BEEF, fnv_pkg::F32_NEG_ZERO}, 1'b0, 64'd0},
        '{fnv_pkg::OP_F32,    64'h0000_0000_7FC0_0001, 1'b0, 64'd0},
        '{fnv_pkg::OP_F32,    64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0},
        '{fnv_pkg::OP_FINISH, 64'd0,                   1'b0, 64'd0}
    };

    fnv1a64_typed_signature dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_operand_value (i_operand_value),
        .empty           (empty),
        .pop             (pop),
        .o_signature     (o_signature)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void mix_bytes(input logic [63:0] word, input int count);
        for (int i = 0; i < count; i++) begin
            running_hash = (running_hash ^ {56'd0, word[8*i +: 8]}) * FNV_PRIME;
        end
    endfunction

    // folds one item into the running hash, returns 1 with the signature on finish
    function automatic bit hash_item(input logic [2:0] op, input logic [63:0] val,
                                     output logic [63:0] sig);
        logic [31:0] low_word;
        low_word = val[31:0];
        sig = 64'd0;
        case (op)
            fnv_pkg::OP_BOOL: begin
                mix_bytes((val != 64'd0) ? 64'd1 : 64'd0, 1);
            end
            fnv_pkg::OP_U32: begin
                mix_bytes({32'd0, low_word}, 4);
            end
            fnv_pkg::OP_U64: begin
                mix_bytes(val, 8);
            end
            fnv_pkg::OP_F32: begin
                if (low_word == fnv_pkg::F32_NEG_ZERO) begin
                    low_word = 32'd0;
                end
                mix_bytes({32'd0, low_word}, 4);
            end
            fnv_pkg::OP_FINISH: begin
                sig = (running_hash == 64'd0) ? 64'd1 : running_hash;
                running_hash = fnv_pkg::FNV_BASIS;
                return 1'b1;
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input logic [2:0] op, input logic [63:0] val,
                             input logic known, input logic [63:0] known_sig);
        int          gap;
        logic [63:0] sig;
        if ($urandom_range(0, 39) == 0) begin
            sender_quiet = !sender_quiet;
        end
        gap = sender_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_opcode <= op;
        i_operand_value <= val;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        if (hash_item(op, val, sig)) begin
            pending_signatures.push_back(known ? known_sig : sig);
        end
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 64'd0;
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return 64'd1 << $urandom_range(0, 63);
            3: return {$urandom, fnv_pkg::F32_NEG_ZERO};
            4: return {32'd0, 24'd0, 8'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // result side: pop with random gaps, check each signature in order
    initial begin
        int          gap;
        logic [63:0] want;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                receiver_quiet = !receiver_quiet;
            end
            gap = receiver_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) begin
                @(posedge i_clk);
            end
            if (pending_signatures.size() == 0) begin
                $error("signature unexpected, actual %h", o_signature);
                failures++;
            end else begin
                want = pending_signatures.pop_front();
                if (o_signature !== want) begin
                    $error("signature expected %h actual %h", want, o_signature);
                    failures++;
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin
        int          folded;
        int          pick;
        logic [2:0]  op;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].val,
                      directed_rows[i].known, directed_rows[i].sig);
        end

        // unused opcodes are sent but not counted
        folded = 0;
        while (folded < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 18) begin
                op = fnv_pkg::OP_BOOL;
            end else if (pick < 38) begin
                op = fnv_pkg::OP_U32;
            end else if (pick < 58) begin
                op = fnv_pkg::OP_U64;
            end else if (pick < 76) begin
                op = fnv_pkg::OP_F32;
            end else if (pick < 94) begin
                op = fnv_pkg::OP_FINISH;
            end else begin
                op = 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
            end
            if (op < OP_SPARE_5) begin
                folded++;
            end
            send_item(op, pick_operand(), 1'b0, 64'd0);
        end
        send_item(fnv_pkg::OP_FINISH, pick_operand(), 1'b0, 64'd0);
        push <= 1'b0;

        while (pending_signatures.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
